/* hdl/acs_pkg.sv */
// ============================================================================
// acs_pkg
// Shared constants and types of the audio chunk crossfade splicer.
// ============================================================================
package acs_pkg;

    // Default configuration of the splicer.
    localparam int unsigned ACS_XFADE     = 32;
    localparam int unsigned ACS_CHUNK_MAX = 65535;

    // Fixed field widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LEN_W    = 16;

    // Weights are unsigned Q0.16 with one extra bit so that 1.0 is representable.
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned WGT_W    = FRAC_W + 1;
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_W;

    // Request to the blend unit.
    typedef struct packed {
        logic                       start;
        logic signed [SAMPLE_W-1:0] tail;
        logic signed [SAMPLE_W-1:0] body;
        logic [WGT_W-1:0]           weight;
    } t_blend_req;

    // Answer of the blend unit.
    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] result;
    } t_blend_rsp;

    // Answer of the weight divider.
    typedef struct packed {
        logic             done;
        logic [WGT_W-1:0] weight;
    } t_wgt_rsp;

endpackage

/* hdl/acs_stream_if.sv */
// ============================================================================
// acs_in_if / acs_out_if
// Valid/ready channels carrying input items and result items of the splicer.
// ============================================================================
interface acs_in_if
    import acs_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [LEN_W-1:0]           chunk_length;
    logic                       final_chunk;

    modport source (output valid, sample_in, chunk_length, final_chunk, input ready);
    modport sink   (input valid, sample_in, chunk_length, final_chunk, output ready);
endinterface

interface acs_out_if
    import acs_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_in_run;

    modport source (output valid, sample_out, last_in_run, input ready);
    modport sink   (input valid, sample_out, last_in_run, output ready);
endinterface

/* hdl/acs_tail_mem.sv */
// ============================================================================
// acs_tail_mem
// Tail sample store: one write port, one read port, registered read data.
// ============================================================================
module acs_tail_mem
    import acs_pkg::*;
#(
    parameter int unsigned DEPTH = ACS_XFADE,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic signed [SAMPLE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic signed [SAMPLE_W-1:0] o_rdata
);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/acs_wdiv.sv */
// ============================================================================
// acs_wdiv
// Crossfade weight divider: round(pos * 2^16 / div), one quotient bit a cycle.
// ============================================================================
module acs_wdiv
    import acs_pkg::*;
#(
    parameter int unsigned CW = $clog2(ACS_XFADE + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_pos,
    input  logic [CW-1:0] i_div,
    output t_wgt_rsp      o_rsp
);

    localparam int unsigned NW = $clog2(FRAC_W + 1);

    logic              r_busy;
    logic [NW-1:0]     r_cnt;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_div;
    logic [FRAC_W-1:0] r_low;
    logic [FRAC_W-1:0] r_quo;
    logic              r_done;
    logic [WGT_W-1:0]  r_wgt;

    logic [CW:0]       trial;
    logic              qbit;
    logic [CW-1:0]     n_rem;
    logic [FRAC_W-1:0] n_quo;

    // Restoring step: the partial remainder stays below the divisor.
    always_comb begin
        trial = {r_rem, r_low[FRAC_W-1]};
        qbit  = (trial >= {1'b0, r_div});
        n_rem = qbit ? CW'(trial - {1'b0, r_div}) : trial[CW-1:0];
        n_quo = {r_quo[FRAC_W-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // A zero divisor or a position equal to it gives full weight.
                if (i_div == '0 || i_pos == i_div) begin
                    r_wgt  <= WGT_ONE;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= NW'(FRAC_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_wgt  <= {1'b0, n_quo};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_pos;
            r_div <= i_div;
            r_low <= FRAC_W'(i_div >> 1);
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_low <= {r_low[FRAC_W-2:0], 1'b0};
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.weight = r_wgt;

endmodule

/* hdl/acs_blend.sv */
// ============================================================================
// acs_blend
// Two-stage linear blend: t + round((b - t) * w / 2^16), rounding half up.
// ============================================================================
module acs_blend
    import acs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_blend_req i_req,
    output t_blend_rsp o_rsp
);

    localparam int unsigned PW = 2 * SAMPLE_W + 3;

    logic signed [SAMPLE_W:0]   diff;
    logic signed [PW-1:0]       prod;
    logic signed [PW-1:0]       r_prod;
    logic signed [SAMPLE_W-1:0] r_tail;
    logic                       r_v1;
    logic signed [PW-1:0]       rounded;
    logic signed [SAMPLE_W-1:0] r_result;
    logic                       r_v2;

    always_comb begin
        diff    = {i_req.body[SAMPLE_W-1], i_req.body} - {i_req.tail[SAMPLE_W-1], i_req.tail};
        prod    = diff * $signed({1'b0, i_req.weight});
        rounded = (r_prod + PW'(32'sd32768)) >>> FRAC_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_req.start;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod <= prod;
            r_tail <= i_req.tail;
        end
        if (r_v1) begin
            // The blend lies between both samples, so the low bits are exact.
            r_result <= r_tail + rounded[SAMPLE_W-1:0];
        end
    end

    assign o_rsp.done   = r_v2;
    assign o_rsp.result = r_result;

endmodule

/* hdl/audio_chunk_crossfade_splicer.sv */
// ============================================================================
// audio_chunk_crossfade_splicer
// Splices successive audio chunks with a linear crossfade over the held tail.
// ============================================================================
// Usage. Items arrive on i_in, one Q1.15 sample per transfer together with its
// chunk length and a final flag; results leave on o_out, each flagged with
// last_in_run on the final result that an item causes. Samples in the tail of
// a non-final chunk are written to the tail memory and produce no transfer.
// Timing. One item is worked on at a time. A plain body sample is loaded into
// the output register from S_BODY_OUT once that register is free, and
// i_in.ready returns in the same cycle. Each held tail sample released at the
// start of a chunk passes through a memory read (S_REL_RD) and an output load
// (S_REL_OUT). A blended sample passes through these steps in order: reading
// the tail and starting the weight divider, the quotient steps of the divider,
// handing over the weight, two blend stages and the output load. A blend at
// full weight skips the quotient steps. Tail samples and dropped samples
// leave the sequencer idle. i_in.ready is high whenever the sequencer is idle,
// also while the last result still sits in the output register; a stall on
// o_out only holds the sequencer when it has a further result to load.
// Reset clears the counters, the sequencer and the output register; the tail
// memory needs no clearing, as no entry is read before it has been written.
// ============================================================================
module audio_chunk_crossfade_splicer
    import acs_pkg::*;
#(
    parameter int unsigned XFADE     = ACS_XFADE,
    parameter int unsigned CHUNK_MAX = ACS_CHUNK_MAX
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    acs_in_if.sink     i_in,
    acs_out_if.source  o_out
);

    // Counts up to XFADE, memory addresses below XFADE.
    localparam int unsigned CW      = $clog2(XFADE + 1);
    localparam int unsigned AW      = (XFADE > 1) ? $clog2(XFADE) : 1;
    localparam int unsigned LenCap  = (CHUNK_MAX < 65535) ? CHUNK_MAX : 65535;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LenCap);
    localparam logic [LEN_W-1:0] XF_LEN  = LEN_W'(XFADE);
    localparam logic [CW-1:0]    XF_CNT  = CW'(XFADE);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b000_0001,
        S_REL_RD   = 7'b000_0010,
        S_REL_OUT  = 7'b000_0100,
        S_BLD_RD   = 7'b000_1000,
        S_BLD_DIV  = 7'b001_0000,
        S_BLD_MUL  = 7'b010_0000,
        S_BODY_OUT = 7'b100_0000
    } t_state;

    // Sequencer and chunk bookkeeping.
    t_state                     r_state, n_state;
    logic [CW-1:0]              r_tc, n_tc;        // samples in the held tail
    logic [LEN_W-1:0]           r_pos, n_pos;      // position within the chunk
    logic [CW-1:0]              r_ov, n_ov;        // overlap of the current chunk
    logic [CW-1:0]              r_ntc, n_ntc;      // tail samples gathered so far

    // Work registers of the item in progress.
    logic [CW-1:0]              r_rel_left, n_rel_left;
    logic [AW-1:0]              r_rel_idx, n_rel_idx;
    logic                       r_blend;
    logic [AW-1:0]              r_baddr;
    logic [CW-1:0]              r_bpos;
    logic [CW-1:0]              r_bdiv;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_result;

    // Output register.
    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample, n_out_sample;
    logic                       r_out_last, n_out_last;

    // Decode of the offered item.
    logic                       accept;
    logic [LEN_W-1:0]           len_c;
    logic                       active;
    logic [LEN_W-1:0]           body;
    logic                       in_body;
    logic                       is_last;
    logic                       first;
    logic [CW-1:0]              ov_new;
    logic [CW-1:0]              ov_eff;
    logic                       blend;
    logic [CW-1:0]              rel;
    logic [LEN_W-1:0]           slot;
    logic                       tail_wr;
    logic [CW-1:0]              ntc_inc;
    logic [CW-1:0]              baddr_full;
    logic                       out_free;

    // Memory and arithmetic units.
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic signed [SAMPLE_W-1:0] mem_rdata;
    logic                       div_start;
    t_wgt_rsp                   div_rsp;
    t_blend_req                 blend_req;
    t_blend_rsp                 blend_rsp;

    assign accept   = i_in.valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || o_out.ready;

    // A zero length counts as one sample; lengths are capped at the chunk limit.
    always_comb begin
        if (i_in.chunk_length == '0) begin
            len_c = LEN_W'(1);
        end else if (i_in.chunk_length > LEN_CAP) begin
            len_c = LEN_CAP;
        end else begin
            len_c = i_in.chunk_length;
        end

        // A non-final chunk of at most XFADE samples is dropped whole.
        active  = i_in.final_chunk || (len_c > XF_LEN);
        body    = i_in.final_chunk ? len_c : len_c - XF_LEN;
        in_body = r_pos < body;
        is_last = ({1'b0, r_pos} + 17'd1) >= {1'b0, len_c};
        first   = active && in_body && (r_pos == '0);

        // Overlap is the smaller of the held tail and the body.
        ov_new  = (LEN_W'(r_tc) <= body) ? r_tc : body[CW-1:0];
        ov_eff  = first ? ov_new : r_ov;
        blend   = active && in_body && (LEN_W'(ov_eff) > r_pos) && (ov_eff <= r_tc);
        rel     = first ? r_tc - ov_new : '0;

        slot    = r_pos - body;
        tail_wr = active && !in_body && (slot < XF_LEN);
        ntc_inc = (tail_wr && r_ntc != XF_CNT) ? r_ntc + CW'(1) : r_ntc;

        // Blend position and tail address fit the count width: pos < overlap.
        baddr_full = r_tc - ov_eff + r_pos[CW-1:0];
    end

    // Sequencer: all chunk bookkeeping is settled in the cycle of the input
    // transfer; the later states read the tail memory, drive the divider and blend, and emit results.
    always_comb begin
        n_state      = r_state;
        n_tc         = r_tc;
        n_pos        = r_pos;
        n_ov         = r_ov;
        n_ntc        = r_ntc;
        n_rel_left   = r_rel_left;
        n_rel_idx    = r_rel_idx;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;
        mem_re       = 1'b0;
        mem_raddr    = r_rel_idx;
        div_start    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ov  = first ? ov_new : r_ov;
                    n_ntc = ntc_inc;
                    if (active && is_last) begin
                        n_tc  = i_in.final_chunk ? '0 : ntc_inc;
                        n_ntc = '0;
                        n_ov  = '0;
                    end
                    n_pos      = is_last ? '0 : r_pos + LEN_W'(1);
                    n_rel_left = rel;
                    n_rel_idx  = '0;
                    if (rel != '0) begin
                        n_state = S_REL_RD;
                    end else if (active && in_body) begin
                        n_state = blend ? S_BLD_RD : S_BODY_OUT;
                    end
                end
            end
            S_REL_RD: begin
                mem_re  = 1'b1;
                n_state = S_REL_OUT;
            end
            S_REL_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = mem_rdata;
                    n_out_last   = 1'b0;
                    n_rel_left   = r_rel_left - CW'(1);
                    n_rel_idx    = r_rel_idx + AW'(1);
                    if (r_rel_left == CW'(1)) begin
                        n_state = r_blend ? S_BLD_RD : S_BODY_OUT;
                    end else begin
                        n_state = S_REL_RD;
                    end
                end
            end
            S_BLD_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_baddr;
                div_start = 1'b1;
                n_state   = S_BLD_DIV;
            end
            S_BLD_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_BLD_MUL;
                end
            end
            S_BLD_MUL: begin
                if (blend_rsp.done) begin
                    n_state = S_BODY_OUT;
                end
            end
            S_BODY_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = r_result;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tc        <= '0;
            r_pos       <= '0;
            r_ov        <= '0;
            r_ntc       <= '0;
            r_rel_left  <= '0;
            r_rel_idx   <= '0;
            r_blend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tc        <= n_tc;
            r_pos       <= n_pos;
            r_ov        <= n_ov;
            r_ntc       <= n_ntc;
            r_rel_left  <= n_rel_left;
            r_rel_idx   <= n_rel_idx;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_blend <= blend;
            end
        end
    end

    // Payload registers of the item in progress and of the output.
    always_ff @(posedge i_clk) begin
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
        if (accept) begin
            r_sample <= i_in.sample_in;
            r_result <= i_in.sample_in;
            r_baddr  <= baddr_full[AW-1:0];
            r_bpos   <= r_pos[CW-1:0];
            r_bdiv   <= ov_eff - CW'(1);
        end else if (blend_rsp.done) begin
            r_result <= blend_rsp.result;
        end
    end

    // Blend is started as soon as the weight is known; the tail sample read in
    // the previous state is still held at the memory output.
    always_comb begin
        blend_req.start  = (r_state == S_BLD_DIV) && div_rsp.done;
        blend_req.tail   = mem_rdata;
        blend_req.body   = r_sample;
        blend_req.weight = div_rsp.weight;
    end

    acs_tail_mem #(
        .DEPTH (XFADE),
        .AW    (AW)
    ) u_tail_mem (
        .i_clk   (i_clk),
        .i_we    (accept && tail_wr),
        .i_waddr (slot[AW-1:0]),
        .i_wdata (i_in.sample_in),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    acs_wdiv #(
        .CW (CW)
    ) u_wdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_pos   (r_bpos),
        .i_div   (r_bdiv),
        .o_rsp   (div_rsp)
    );

    acs_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (blend_req),
        .o_rsp   (blend_rsp)
    );

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.sample_out  = r_out_sample;
    assign o_out.last_in_run = r_out_last;

endmodule

/* hdl/acs_checker.sv */
// ============================================================================
// acs_checker
// Port-level checks of the splicer, attached to the top level by bind.
// ============================================================================
module acs_checker
    import acs_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic signed [SAMPLE_W-1:0] i_out_sample,
    input logic                       i_out_last
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_sample) && $stable(i_out_last))
        else $error("result payload changed while stalled");

    // Reset leaves no result offered.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // Reset leaves the block ready for an item.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("not ready after reset");

    // While a result that is not the last of its item waits, the item is
    // still being worked on, so no new item may be taken.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("new item taken before its predecessor finished");

endmodule

bind audio_chunk_crossfade_splicer acs_checker u_acs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_last   (o_out.last_in_run)
);
